// ===== rtl/mstk_pkg.sv =====
`default_nettype none

package mstk_pkg;

    // Graph size and derived widths
    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int COUNT_W   = $clog2(MAX_NODES + 1);
    localparam int LINK_W    = COUNT_W;
    localparam int ADDR_W    = 2 * NODE_W;

    // Field widths
    localparam int COST_W  = 10;
    localparam int SUM_W   = 14;
    localparam int NC_W    = 5;
    localparam int STAT_W  = 2;

    // Register port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REGIDX_W = PADDR_W - 2;

    localparam logic [REGIDX_W-1:0] REG_NODE_COUNT = 1'b0;
    localparam logic [NC_W-1:0]     NC_RESET       = 5'd16;

    localparam logic [COST_W-1:0] NO_EDGE = 10'd999;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_BUSY = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_DISC = 2'd2;

    typedef enum logic [1:0] {
        EK_EDGE,
        EK_DISC,
        EK_SOLO
    } t_emit_kind;

    typedef struct packed {
        logic       load_wr;
        logic       run_init;
        logic       scan_init;
        logic       scan_step;
        logic       walk_a;
        logic       walk_step;
        logic       root_a;
        logic       link;
        logic       clr_ab;
        logic       clr_ba;
        logic       push;
        t_emit_kind push_kind;
    } t_cmd;

    typedef struct packed {
        logic edges_done;
        logic single;
        logic scan_last;
        logic best_none;
        logic walk_root;
        logic roots_differ;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/mstk_ctrl.sv =====
`default_nettype none

module mstk_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_load_last,
    input  mstk_pkg::t_stat     i_stat,
    output mstk_pkg::t_cmd      o_cmd,
    output logic                o_in_stall
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_TEST   = 13'b0000000000010,
        S_SCAN   = 13'b0000000000100,
        S_DRAIN  = 13'b0000000001000,
        S_CHECK  = 13'b0000000010000,
        S_FIND_A = 13'b0000000100000,
        S_FIND_B = 13'b0000001000000,
        S_LINK   = 13'b0000010000000,
        S_EMIT   = 13'b0000100000000,
        S_CLR_AB = 13'b0001000000000,
        S_CLR_BA = 13'b0010000000000,
        S_DISC   = 13'b0100000000000,
        S_SOLO   = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_load_last) begin
                        o_cmd.run_init = 1'b1;
                        n_state        = S_TEST;
                    end
                end
            end
            S_TEST: begin
                if (i_stat.edges_done) begin
                    n_state = i_stat.single ? S_SOLO : S_IDLE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.best_none) begin
                    n_state = S_DISC;
                end else begin
                    o_cmd.walk_a = 1'b1;
                    n_state      = S_FIND_A;
                end
            end
            S_FIND_A: begin
                if (i_stat.walk_root) begin
                    o_cmd.root_a = 1'b1;
                    n_state      = S_FIND_B;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_FIND_B: begin
                if (i_stat.walk_root) begin
                    n_state = S_LINK;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_LINK: begin
                if (i_stat.roots_differ) begin
                    o_cmd.link = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    n_state = S_CLR_AB;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = mstk_pkg::EK_EDGE;
                    n_state         = S_CLR_AB;
                end
            end
            S_CLR_AB: begin
                o_cmd.clr_ab = 1'b1;
                n_state      = S_CLR_BA;
            end
            S_CLR_BA: begin
                o_cmd.clr_ba = 1'b1;
                n_state      = S_TEST;
            end
            S_DISC: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = mstk_pkg::EK_DISC;
                    n_state         = S_IDLE;
                end
            end
            S_SOLO: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = mstk_pkg::EK_SOLO;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mstk_dp.sv =====
`default_nettype none

module mstk_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  mstk_pkg::t_cmd                       i_cmd,
    output mstk_pkg::t_stat                      o_stat,
    input  wire [mstk_pkg::NC_W-1:0]             i_node_count,
    input  wire [mstk_pkg::NODE_W-1:0]           i_row_node,
    input  wire [mstk_pkg::NODE_W-1:0]           i_col_node,
    input  wire [mstk_pkg::COST_W-1:0]           i_edge_cost,
    input  wire                                  i_out_stall,
    output logic                                 o_out_valid,
    output logic                                 o_edge_valid,
    output logic [mstk_pkg::NODE_W-1:0]          o_edge_from,
    output logic [mstk_pkg::NODE_W-1:0]          o_edge_to,
    output logic [mstk_pkg::COST_W-1:0]          o_edge_weight,
    output logic [mstk_pkg::SUM_W-1:0]           o_total_cost,
    output logic [mstk_pkg::STAT_W-1:0]          o_status,
    output logic                                 o_run_last
);

    // Cost matrix, addressed {row, col}
    logic [mstk_pkg::COST_W-1:0] r_cost_mem [2**mstk_pkg::ADDR_W];
    logic [mstk_pkg::COST_W-1:0] r_rd_data;
    logic [mstk_pkg::NODE_W-1:0] r_rd_i;
    logic [mstk_pkg::NODE_W-1:0] r_rd_j;
    logic                        r_rd_v;

    logic                        w_wr_en;
    logic [mstk_pkg::ADDR_W-1:0] w_wr_addr;
    logic [mstk_pkg::COST_W-1:0] w_wr_data;

    // Union-find links, parent + 1 (zero marks a root)
    logic [mstk_pkg::LINK_W-1:0] r_parent [mstk_pkg::MAX_NODES];
    logic [mstk_pkg::LINK_W-1:0] w_par;

    logic [mstk_pkg::NODE_W-1:0]  r_si;
    logic [mstk_pkg::NODE_W-1:0]  r_sj;
    logic [mstk_pkg::COST_W-1:0]  r_best;
    logic [mstk_pkg::NODE_W-1:0]  r_a;
    logic [mstk_pkg::NODE_W-1:0]  r_b;
    logic [mstk_pkg::NODE_W-1:0]  r_walk;
    logic [mstk_pkg::NODE_W-1:0]  r_root_a;
    logic [mstk_pkg::COUNT_W-1:0] r_edges;
    logic [mstk_pkg::SUM_W-1:0]   r_sum;

    logic [mstk_pkg::COUNT_W-1:0] w_n;
    logic [mstk_pkg::COUNT_W-1:0] w_nm1;
    logic [mstk_pkg::NODE_W-1:0]  w_last_idx;
    logic                         w_pos_ok;

    // Clamp the node count into 1..MAX_NODES
    always_comb begin
        if (i_node_count == '0) begin
            w_n = mstk_pkg::COUNT_W'(1);
        end else if (int'(i_node_count) > mstk_pkg::MAX_NODES) begin
            w_n = mstk_pkg::COUNT_W'(mstk_pkg::MAX_NODES);
        end else begin
            w_n = mstk_pkg::COUNT_W'(i_node_count);
        end
        w_nm1      = w_n - mstk_pkg::COUNT_W'(1);
        w_last_idx = w_nm1[mstk_pkg::NODE_W-1:0];
    end

    assign w_pos_ok = (int'(i_row_node) < mstk_pkg::MAX_NODES) &&
                      (int'(i_col_node) < mstk_pkg::MAX_NODES);

    // Single write port: loads while idle, mirror clears during a run
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = {i_row_node, i_col_node};
        w_wr_data = i_edge_cost;
        if (i_cmd.load_wr) begin
            w_wr_en = w_pos_ok;
        end else if (i_cmd.clr_ab) begin
            w_wr_en   = 1'b1;
            w_wr_addr = {r_a, r_b};
            w_wr_data = mstk_pkg::NO_EDGE;
        end else if (i_cmd.clr_ba) begin
            w_wr_en   = 1'b1;
            w_wr_addr = {r_b, r_a};
            w_wr_data = mstk_pkg::NO_EDGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_cost_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_cost_mem[{r_si, r_sj}];
        r_rd_i    <= r_si;
        r_rd_j    <= r_sj;
    end

    assign w_par = r_parent[r_walk];

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_edges <= '0;
            r_sum   <= '0;
            r_si    <= '0;
            r_sj    <= '0;
            for (int k = 0; k < mstk_pkg::MAX_NODES; k++) begin
                r_parent[k] <= '0;
            end
        end else begin
            r_rd_v <= i_cmd.scan_step;
            if (i_cmd.run_init) begin
                r_edges <= '0;
                r_sum   <= '0;
                for (int k = 0; k < mstk_pkg::MAX_NODES; k++) begin
                    r_parent[k] <= '0;
                end
            end
            if (i_cmd.scan_init) begin
                r_si <= '0;
                r_sj <= '0;
            end else if (i_cmd.scan_step) begin
                if (r_sj == w_last_idx) begin
                    r_sj <= '0;
                    r_si <= r_si + mstk_pkg::NODE_W'(1);
                end else begin
                    r_sj <= r_sj + mstk_pkg::NODE_W'(1);
                end
            end
            if (i_cmd.link) begin
                r_parent[r_walk] <= mstk_pkg::LINK_W'(r_root_a) + mstk_pkg::LINK_W'(1);
                r_edges          <= r_edges + mstk_pkg::COUNT_W'(1);
                r_sum            <= r_sum + mstk_pkg::SUM_W'(r_best);
            end
        end
    end

    // Scan minimum and root walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_best <= mstk_pkg::NO_EDGE;
            r_a    <= '0;
            r_b    <= '0;
        end else if (r_rd_v && (r_rd_data < r_best)) begin
            r_best <= r_rd_data;
            r_a    <= r_rd_i;
            r_b    <= r_rd_j;
        end
        if (i_cmd.walk_a) begin
            r_walk <= r_a;
        end else if (i_cmd.root_a) begin
            r_root_a <= r_walk;
            r_walk   <= r_b;
        end else if (i_cmd.walk_step && (w_par != '0)) begin
            r_walk <= mstk_pkg::NODE_W'(w_par - mstk_pkg::LINK_W'(1));
        end
    end

    always_comb begin
        o_stat.edges_done   = (r_edges == w_nm1);
        o_stat.single       = (w_n == mstk_pkg::COUNT_W'(1));
        o_stat.scan_last    = (r_si == w_last_idx) && (r_sj == w_last_idx);
        o_stat.best_none    = (r_best >= mstk_pkg::NO_EDGE);
        o_stat.walk_root    = (w_par == '0);
        o_stat.roots_differ = (r_root_a != r_walk);
        o_stat.out_free     = !o_out_valid || !i_out_stall;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_total_cost <= r_sum;
            case (i_cmd.push_kind)
                mstk_pkg::EK_EDGE: begin
                    o_edge_valid  <= 1'b1;
                    o_edge_from   <= r_a;
                    o_edge_to     <= r_b;
                    o_edge_weight <= r_best;
                    o_status      <= o_stat.edges_done ? mstk_pkg::ST_DONE
                                                       : mstk_pkg::ST_BUSY;
                    o_run_last    <= o_stat.edges_done;
                end
                mstk_pkg::EK_DISC: begin
                    o_edge_valid  <= 1'b0;
                    o_edge_from   <= '0;
                    o_edge_to     <= '0;
                    o_edge_weight <= '0;
                    o_status      <= mstk_pkg::ST_DISC;
                    o_run_last    <= 1'b1;
                end
                default: begin
                    o_edge_valid  <= 1'b0;
                    o_edge_from   <= '0;
                    o_edge_to     <= '0;
                    o_edge_weight <= '0;
                    o_status      <= mstk_pkg::ST_DONE;
                    o_run_last    <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/min_spanning_tree_kruskal.sv =====
`default_nettype none

// Minimum spanning tree engine (Kruskal) over a cost matrix of up to 16 x 16
// entries. Load the matrix one entry per item, one item per cycle, at
// (row_node, col_node); a cost of 999 or more means no edge, and positions
// outside the matrix are dropped. The item flagged load_last stores its entry
// and starts a run over the first node_count nodes (register at byte 0, reset
// 16; 0 acts as 1, above 16 acts as 16). Each round scans all n*n active
// entries through the single read port of the cost memory, one entry per
// cycle, then walks the parent links of both ends one hop per cycle (at most
// n-1 hops each), links the roots when they differ and emits the edge, and
// finally writes 999 into the entry and its mirror. A run takes one round per
// entry pair it consumes. The input is stalled from the load_last item until
// the sequencer is idle again after the run's final result has entered the
// output register. Each result reports the chosen edge and the running total;
// the last one of a run carries run_last, with status 1 when the tree is
// complete and status 2 when the graph turned out to be disconnected (then an
// extra result without an edge closes the run). A single-node run gives one
// closing result with status 1. The cost memory is not cleared by reset:
// every scanned entry must be loaded first.
module min_spanning_tree_kruskal (
    input  wire                                i_clk,
    input  wire                                i_rst_n,

    // matrix entry channel
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire [mstk_pkg::NODE_W-1:0]         i_row_node,
    input  wire [mstk_pkg::NODE_W-1:0]         i_col_node,
    input  wire [mstk_pkg::COST_W-1:0]         i_edge_cost,
    input  wire                                i_load_last,

    // result channel
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic                               o_edge_valid,
    output logic [mstk_pkg::NODE_W-1:0]        o_edge_from,
    output logic [mstk_pkg::NODE_W-1:0]        o_edge_to,
    output logic [mstk_pkg::COST_W-1:0]        o_edge_weight,
    output logic [mstk_pkg::SUM_W-1:0]         o_total_cost,
    output logic [mstk_pkg::STAT_W-1:0]        o_status,
    output logic                               o_run_last,

    // register port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [mstk_pkg::PADDR_W-1:0]        paddr,
    input  wire [mstk_pkg::PDATA_W-1:0]        pwdata,
    output logic [mstk_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    logic [mstk_pkg::NC_W-1:0]     r_node_count;
    logic [mstk_pkg::REGIDX_W-1:0] w_reg_idx;

    mstk_pkg::t_cmd  w_cmd;
    mstk_pkg::t_stat w_stat;

    // Register port: zero wait states, writes on the access phase
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[mstk_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= mstk_pkg::NC_RESET;
        end else if (psel && penable && pwrite &&
                     (w_reg_idx == mstk_pkg::REG_NODE_COUNT)) begin
            r_node_count <= pwdata[mstk_pkg::NC_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_idx == mstk_pkg::REG_NODE_COUNT) begin
            prdata = mstk_pkg::PDATA_W'(r_node_count);
        end
    end

    // Sequencer: loads, scan rounds, root walks, clears and result pushes
    mstk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_load_last (i_load_last),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall)
    );

    // Cost memory, union-find links, running sums and the output register
    mstk_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_node_count  (r_node_count),
        .i_row_node    (i_row_node),
        .i_col_node    (i_col_node),
        .i_edge_cost   (i_edge_cost),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_edge_valid  (o_edge_valid),
        .o_edge_from   (o_edge_from),
        .o_edge_to     (o_edge_to),
        .o_edge_weight (o_edge_weight),
        .o_total_cost  (o_total_cost),
        .o_status      (o_status),
        .o_run_last    (o_run_last)
    );

endmodule

`default_nettype wire

// ===== rtl/mstk_check.sv =====
`default_nettype none

module mstk_check (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_out_valid,
    input wire                            i_out_stall,
    input wire                            i_edge_valid,
    input wire [mstk_pkg::NODE_W-1:0]     i_edge_from,
    input wire [mstk_pkg::NODE_W-1:0]     i_edge_to,
    input wire [mstk_pkg::COST_W-1:0]     i_edge_weight,
    input wire [mstk_pkg::SUM_W-1:0]      i_total_cost,
    input wire [mstk_pkg::STAT_W-1:0]     i_status,
    input wire                            i_run_last
);

    // A stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=>
            i_out_valid && $stable(i_edge_weight) && $stable(i_total_cost) &&
            $stable(i_status) && $stable(i_run_last))
        else $error("stalled result changed");

    // Items without an edge close the run and carry empty edge fields
    a_close_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_edge_valid |->
            i_run_last && (i_edge_from == '0) && (i_edge_to == '0) &&
            (i_edge_weight == '0) && (i_status != mstk_pkg::ST_BUSY))
        else $error("malformed closing result");

    // run_last and a final status go together
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_run_last == (i_status != mstk_pkg::ST_BUSY)))
        else $error("run_last and status disagree");

    // A chosen edge is a real edge and never reports disconnection
    a_edge_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_edge_valid |->
            (i_edge_weight < mstk_pkg::NO_EDGE) && (i_status != mstk_pkg::ST_DISC))
        else $error("chosen edge has no-edge cost or bad status");

endmodule

bind min_spanning_tree_kruskal mstk_check u_mstk_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .i_edge_valid  (o_edge_valid),
    .i_edge_from   (o_edge_from),
    .i_edge_to     (o_edge_to),
    .i_edge_weight (o_edge_weight),
    .i_total_cost  (o_total_cost),
    .i_status      (o_status),
    .i_run_last    (o_run_last)
);

`default_nettype wire
